[rtl/pios_pkg.sv]
// Shared types and constants for the per-instrument order statistics unit.
package pios_pkg;

    localparam int ID_W    = 12;
    localparam int SIZE_W  = 32;
    localparam int PRICE_W = 32;
    localparam int COUNT_W = 32;
    localparam int NET_W   = 48;
    localparam int VOL_W   = 48;
    localparam int PV_W    = 63;
    localparam int PROD_W  = SIZE_W + PRICE_W;

    localparam logic MODE_APPLY = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [NET_W-1:0]   NET_MAX   = {1'b0, {(NET_W-1){1'b1}}};
    localparam logic [NET_W-1:0]   NET_MIN   = {1'b1, {(NET_W-1){1'b0}}};
    localparam logic [VOL_W-1:0]   VOL_MAX   = {VOL_W{1'b1}};
    localparam logic [PV_W-1:0]    PV_MAX    = {PV_W{1'b1}};

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [NET_W-1:0]   net;
        logic [VOL_W-1:0]   vol;
        logic [PV_W-1:0]    pv;
        logic [PRICE_W-1:0] last;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_CALC
    } t_state;

endpackage

[rtl/pios_ram.sv]
// Generic simple dual-port RAM with registered read.
module pios_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/per_instrument_order_stats_unit.sv]
// Top level of the per-instrument order statistics unit.
// Keeps count, net size, traded volume, size-times-price sum and last price per
// instrument in a table indexed by the low INSTRUMENT_BITS bits of the id. A mode 0
// request applies an order and returns the updated entry; a mode 1 request returns
// the entry unchanged (all zero with present low if the instrument never traded).
// Accumulators saturate. From acceptance to result, a request runs the table read
// alongside the size-times-price multiply, then the update and write-back. A new
// request is taken only once the previous one is done; a stalled result holds the
// update step. After reset a clearing pass over all 2**INSTRUMENT_BITS entries
// resets the valid table; o_in_ready stays low during it.
module per_instrument_order_stats_unit
    import pios_pkg::*;
#(
    parameter int INSTRUMENT_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_mode,
    input  logic [ID_W-1:0]           i_instrument_id,
    input  logic signed [SIZE_W-1:0]  i_order_size,
    input  logic [PRICE_W-1:0]        i_order_price,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_present,
    output logic [COUNT_W-1:0]        o_order_count,
    output logic signed [NET_W-1:0]   o_net_quantity,
    output logic [VOL_W-1:0]          o_traded_volume,
    output logic [PV_W-1:0]           o_price_volume_sum,
    output logic [PRICE_W-1:0]        o_latest_price
);

    localparam int DEPTH    = 1 << INSTRUMENT_BITS;
    localparam int ID_EXT_W = (INSTRUMENT_BITS > ID_W) ? INSTRUMENT_BITS : ID_W;

    t_state r_state, n_state;

    logic [INSTRUMENT_BITS-1:0] r_clr_addr;
    logic [INSTRUMENT_BITS-1:0] r_idx;
    logic                       r_mode;
    logic [SIZE_W-1:0]          r_size;
    logic [PRICE_W-1:0]         r_price;
    logic [SIZE_W-1:0]          r_mag;
    logic [PROD_W-1:0]          r_prod;

    logic   r_out_valid;
    logic   r_out_present;
    t_entry r_out;

    logic [ID_EXT_W-1:0]        w_id_ext;
    logic [INSTRUMENT_BITS-1:0] w_idx;
    logic [SIZE_W-1:0]          w_mag;
    logic                       w_accept;
    logic                       w_out_free;
    logic                       w_done;

    logic                       w_vld_wr_en;
    logic [INSTRUMENT_BITS-1:0] w_vld_wr_addr;
    logic                       w_vld_wr_data;
    logic                       w_vld_rd;
    logic                       w_dat_wr_en;
    logic [ENTRY_W-1:0]         w_dat_rd;

    t_entry w_old;
    t_entry w_new;
    t_entry w_res;

    logic [NET_W:0]  w_net_sum;
    logic [VOL_W:0]  w_vol_sum;
    logic [PV_W:0]   w_pv_sum;

    assign w_id_ext   = ID_EXT_W'(i_instrument_id);
    assign w_idx      = w_id_ext[INSTRUMENT_BITS-1:0];
    assign w_mag      = i_order_size[SIZE_W-1] ? (~i_order_size + 1'b1) : i_order_size;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_done     = (r_state == ST_CALC) && w_out_free;

    // valid table: cleared by the sweep, set on every applied order
    assign w_vld_wr_en   = (r_state == ST_CLEAR) || (w_done && r_mode == MODE_APPLY);
    assign w_vld_wr_addr = (r_state == ST_CLEAR) ? r_clr_addr : r_idx;
    assign w_vld_wr_data = (r_state != ST_CLEAR);
    assign w_dat_wr_en   = w_done && (r_mode == MODE_APPLY);

    pios_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_valid_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_vld_wr_en),
        .i_wr_addr (w_vld_wr_addr),
        .i_wr_data (w_vld_wr_data),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_idx),
        .o_rd_data (w_vld_rd)
    );

    pios_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_dat_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (w_new),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_idx),
        .o_rd_data (w_dat_rd)
    );

    // read data holds until the next accepted request
    assign w_old = t_entry'(w_dat_rd);

    always_comb begin
        w_net_sum = {w_old.net[NET_W-1], w_old.net}
                  + {{(NET_W+1-SIZE_W){r_size[SIZE_W-1]}}, r_size};
        w_vol_sum = {1'b0, w_old.vol} + (VOL_W+1)'(r_mag);
        w_pv_sum  = {1'b0, w_old.pv} + (PV_W+1)'(r_prod);

        if (!w_vld_rd) begin
            w_new.count = COUNT_W'(1);
            w_new.net   = {{(NET_W-SIZE_W){r_size[SIZE_W-1]}}, r_size};
            w_new.vol   = VOL_W'(r_mag);
            w_new.pv    = r_prod[PV_W-1:0];
        end else begin
            w_new.count = (w_old.count == COUNT_MAX) ? COUNT_MAX : w_old.count + 1'b1;
            if (w_net_sum[NET_W] != w_net_sum[NET_W-1]) begin
                w_new.net = w_net_sum[NET_W] ? NET_MIN : NET_MAX;
            end else begin
                w_new.net = w_net_sum[NET_W-1:0];
            end
            w_new.vol = w_vol_sum[VOL_W] ? VOL_MAX : w_vol_sum[VOL_W-1:0];
            w_new.pv  = w_pv_sum[PV_W] ? PV_MAX : w_pv_sum[PV_W-1:0];
        end
        w_new.last = r_price;

        if (r_mode == MODE_APPLY) begin
            w_res = w_new;
        end else if (w_vld_rd) begin
            w_res = w_old;
        end else begin
            w_res = '0;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == {INSTRUMENT_BITS{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx   <= w_idx;
            r_mode  <= i_mode;
            r_size  <= i_order_size;
            r_price <= i_order_price;
            r_mag   <= w_mag;
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(r_price);
        end
        if (w_done) begin
            r_out         <= w_res;
            r_out_present <= w_vld_rd || (r_mode == MODE_APPLY);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_present          = r_out_present;
    assign o_order_count      = r_out.count;
    assign o_net_quantity     = r_out.net;
    assign o_traded_volume    = r_out.vol;
    assign o_price_volume_sum = r_out.pv;
    assign o_latest_price     = r_out.last;

endmodule

[rtl/pios_checker.sv]
// Port-level assertions for the per-instrument order statistics unit, with bind.
module pios_checker
    import pios_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     i_mode,
    input logic [ID_W-1:0]          i_instrument_id,
    input logic signed [SIZE_W-1:0] i_order_size,
    input logic [PRICE_W-1:0]       i_order_price,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic                     o_present,
    input logic [COUNT_W-1:0]       o_order_count,
    input logic signed [NET_W-1:0]  o_net_quantity,
    input logic [VOL_W-1:0]         o_traded_volume,
    input logic [PV_W-1:0]          o_price_volume_sum,
    input logic [PRICE_W-1:0]       o_latest_price
);

    logic [NET_W-1:0] w_net_mag;

    assign w_net_mag = o_net_quantity[NET_W-1] ? (~o_net_quantity + 1'b1) : o_net_quantity;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_present)
            && $stable(o_order_count) && $stable(o_net_quantity)
            && $stable(o_traded_volume) && $stable(o_price_volume_sum)
            && $stable(o_latest_price))
        else $error("result changed while stalled");

    // an absent instrument reads as all zero
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_present |-> o_order_count == '0 && o_net_quantity == '0
            && o_traded_volume == '0 && o_price_volume_sum == '0 && o_latest_price == '0)
        else $error("absent entry with nonzero fields");

    a_present_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_present |-> o_order_count != '0)
        else $error("present entry with zero count");

    // sum of magnitudes bounds the magnitude of the signed sum, saturation included
    a_volume_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_present |-> o_traded_volume >= w_net_mag)
        else $error("traded volume below net magnitude");

endmodule

bind per_instrument_order_stats_unit pios_checker u_pios_checker (.*);
